// ===== hw/rtl/spa_pkg.sv =====
// Shared types, codes and defaults of the slot pool allocator.
package spa_pkg;

    localparam int SPA_NUM_BANKS = 8;
    localparam int SPA_SLOTS     = 64;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } spa_op_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_SPACE     = 2'd1,
        STAT_BOGUS        = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } spa_status_t;

    localparam logic [1:0] REG_SLOTS_PER_PUDDLE = 2'd0;
    localparam logic [1:0] REG_NEVER_FREE       = 2'd1;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_EXEC = 2'd1,
        BK_POP  = 2'd2,
        BK_WAIT = 2'd3
    } spa_bk_state_t;

    typedef struct packed {
        spa_op_t    op;
        logic [2:0] puddle_index;
        logic [5:0] slot_index;
    } spa_cmd_t;

    typedef struct packed {
        logic [9:0]  total_used;
        logic        is_allocated;
        logic [5:0]  granted_slot;
        logic [2:0]  granted_puddle;
        spa_status_t status;
    } spa_result_t;

    typedef struct packed {
        logic     valid;
        spa_cmd_t cmd;
    } spa_queue_out_t;

endpackage

// ===== hw/rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spa_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/spa_front.sv =====
// Front end: accepts items, decodes the operation and queues up to two commands.
module spa_front
    import spa_pkg::*;
    (
        input  logic           clk,
        input  logic           rst_n,
        input  logic           in_valid,
        output logic           in_ready,
        input  logic [15:0]    in_data,
        output spa_queue_out_t q_out,
        input  logic           q_ready
    );

    spa_cmd_t    entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    spa_cmd_t    dec;
    logic        push, pop;

    always_comb
    begin
        dec.op           = spa_op_t'(in_data[1:0]);
        dec.puddle_index = in_data[4:2];
        dec.slot_index   = in_data[10:5];
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.cmd   = entry_reg[rd_ptr_reg];
    assign pop       = q_out.valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== hw/rtl/spa_back.sv =====
// Back end: bank state, free lists, bank chain and available list, result register.
module spa_back
    import spa_pkg::*;
    #(
        parameter int NUM_BANKS = SPA_NUM_BANKS,
        parameter int SLOTS     = SPA_SLOTS
    )
    (
        input  logic           clk,
        input  logic           rst_n,
        input  spa_queue_out_t q_in,
        output logic           q_ready,
        input  logic           cfg_valid,
        input  logic [1:0]     cfg_index,
        input  logic [6:0]     cfg_data,
        output logic           out_valid,
        input  logic           out_ready,
        output spa_result_t    out_data
    );

    localparam int IW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int LW = IW + 1;                  // bank link, msb marks null
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = SW + 1;                  // slot pointer, msb marks null
    localparam int DEPTH = NUM_BANKS * SLOTS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] LNIL = {1'b1, {IW{1'b0}}};
    localparam logic [HW-1:0] SNIL = {1'b1, {SW{1'b0}}};

    spa_bk_state_t state_reg, state_next;
    spa_cmd_t      cmd_reg, cmd_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [6:0]    spp_reg, spp_next;
    logic          nf_reg, nf_next;

    logic [NUM_BANKS-1:0] active_reg, active_next;
    logic [SLOTS-1:0]     used_reg [NUM_BANKS];
    logic [SLOTS-1:0]     used_next [NUM_BANKS];
    logic [HW-1:0]        head_reg [NUM_BANKS];
    logic [HW-1:0]        head_next [NUM_BANKS];
    logic [HW-1:0]        fresh_reg [NUM_BANKS];
    logic [HW-1:0]        fresh_next [NUM_BANKS];
    logic [HW-1:0]        cnt_reg [NUM_BANKS];
    logic [HW-1:0]        cnt_next [NUM_BANKS];
    logic [LW-1:0]        av_nxt_reg [NUM_BANKS];
    logic [LW-1:0]        av_nxt_next [NUM_BANKS];
    logic [LW-1:0]        av_prv_reg [NUM_BANKS];
    logic [LW-1:0]        av_prv_next [NUM_BANKS];
    logic [LW-1:0]        ch_nxt_reg [NUM_BANKS];
    logic [LW-1:0]        ch_nxt_next [NUM_BANKS];
    logic [LW-1:0]        ch_prv_reg [NUM_BANKS];
    logic [LW-1:0]        ch_prv_next [NUM_BANKS];
    logic [LW-1:0]        ch_head_reg, ch_head_next;
    logic [LW-1:0]        av_head_reg, av_head_next;
    logic [TW-1:0]        total_reg, total_next;

    logic          out_valid_reg, out_valid_next;
    spa_result_t   res_reg, res_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [HW-1:0] mem_wdata, mem_rdata;

    spa_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_free_next (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        logic [HW-1:0] n;
        logic          idle_found;
        logic [IW-1:0] idle_idx;
        logic [IW-1:0] pbi;
        logic [SW-1:0] psi;
        logic [SW-1:0] s;
        logic [HW-1:0] nxt;
        logic          bad;
        logic          was_full;
        logic          do_clear, do_pop, do_finish;
        logic          unlink_en, push_en;
        logic [IW-1:0] ub;
        logic [LW-1:0] lnx, lpv, old;
        spa_status_t   f_status;
        logic [IW-1:0] f_bank;
        logic [SW-1:0] f_slot;
        logic          f_isal;

        // working slot count, clamped to 1..SLOTS
        if (spp_reg == 7'd0)
            n = HW'(1);
        else if (int'(spp_reg) > SLOTS)
            n = HW'(SLOTS);
        else
            n = HW'(spp_reg);

        idle_found = 1'b0;
        idle_idx   = '0;
        for (int k = NUM_BANKS - 1; k >= 0; k--)
        begin
            if (!active_reg[k])
            begin
                idle_found = 1'b1;
                idle_idx   = IW'(k);
            end
        end

        pbi = IW'(cmd_reg.puddle_index);
        psi = SW'(cmd_reg.slot_index);
        s   = head_reg[cur_reg][SW-1:0];
        nxt = mem_rdata;
        bad = 1'b0;
        was_full  = 1'b0;
        do_clear  = 1'b0;
        do_pop    = 1'b0;
        do_finish = 1'b0;
        unlink_en = 1'b0;
        push_en   = 1'b0;
        ub        = cur_reg;
        lnx = LNIL;
        lpv = LNIL;
        old = LNIL;
        f_status = STAT_OK;
        f_bank   = '0;
        f_slot   = '0;
        f_isal   = 1'b0;

        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        spp_next    = spp_reg;
        nf_next     = nf_reg;
        active_next = active_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        fresh_next  = fresh_reg;
        cnt_next    = cnt_reg;
        av_nxt_next = av_nxt_reg;
        av_prv_next = av_prv_reg;
        ch_nxt_next = ch_nxt_reg;
        ch_prv_next = ch_prv_reg;
        ch_head_next = ch_head_reg;
        av_head_next = av_head_reg;
        total_next   = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next  = res_reg;
        q_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = AW'(pbi) * AW'(SLOTS) + AW'(psi);
        mem_raddr = AW'(cur_reg) * AW'(SLOTS) + AW'(s);
        mem_wdata = head_reg[pbi];

        if (cfg_valid)
        begin
            if (cfg_index == REG_SLOTS_PER_PUDDLE)
            begin
                spp_next = cfg_data;
                do_clear = 1'b1;
            end
            else if (cfg_index == REG_NEVER_FREE)
            begin
                nf_next = cfg_data[0];
            end
        end

        case (state_reg)
            BK_IDLE:
            begin
                q_ready = !out_valid_reg || out_ready;
                if (q_in.valid && q_ready)
                begin
                    cmd_next   = q_in.cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                case (cmd_reg.op)
                    OP_CLEAR:
                    begin
                        do_clear  = 1'b1;
                        do_finish = 1'b1;
                    end
                    OP_FREE, OP_QUERY:
                    begin
                        do_finish = 1'b1;
                        bad = (int'(cmd_reg.puddle_index) >= NUM_BANKS) || !active_reg[pbi]
                            || (int'(cmd_reg.slot_index) >= int'(n));
                        if (bad)
                            f_status = STAT_BOGUS;
                        else if (cmd_reg.op == OP_QUERY)
                            f_isal = used_reg[pbi][psi];
                        else if (!used_reg[pbi][psi])
                            f_status = STAT_ALREADY_FREE;
                        else
                        begin
                            was_full = head_reg[pbi][SW];
                            used_next[pbi][psi] = 1'b0;
                            cnt_next[pbi] = cnt_reg[pbi] - HW'(1);
                            total_next = total_reg - TW'(1);
                            mem_we = 1'b1;
                            head_next[pbi] = HW'(psi);
                            if ((cnt_next[pbi] == '0) && !nf_reg)
                            begin
                                lnx = ch_nxt_reg[pbi];
                                lpv = ch_prv_reg[pbi];
                                if (!lpv[IW])
                                begin
                                    ch_nxt_next[lpv[IW-1:0]] = lnx;
                                    if (!lnx[IW])
                                        ch_prv_next[lnx[IW-1:0]] = lpv;
                                    unlink_en = 1'b1;
                                end
                                else if (lnx[IW])
                                begin
                                    // last active bank stays on
                                    push_en = was_full;
                                end
                                else
                                begin
                                    ch_head_next = lnx;
                                    ch_prv_next[lnx[IW-1:0]] = LNIL;
                                    unlink_en = 1'b1;
                                end
                                if (unlink_en)
                                begin
                                    ch_nxt_next[pbi] = LNIL;
                                    ch_prv_next[pbi] = LNIL;
                                    active_next[pbi] = 1'b0;
                                end
                            end
                            else
                            begin
                                push_en = was_full;
                            end
                            ub = pbi;
                        end
                    end
                    default: // OP_ALLOC
                    begin
                        if (!av_head_reg[IW])
                        begin
                            cur_next   = av_head_reg[IW-1:0];
                            state_next = BK_POP;
                        end
                        else if (idle_found)
                        begin
                            active_next[idle_idx] = 1'b1;
                            used_next[idle_idx]   = '0;
                            cnt_next[idle_idx]    = '0;
                            head_next[idle_idx]   = '0;
                            fresh_next[idle_idx]  = '0;
                            ch_prv_next[idle_idx] = LNIL;
                            ch_nxt_next[idle_idx] = ch_head_reg;
                            if (!ch_head_reg[IW])
                                ch_prv_next[ch_head_reg[IW-1:0]] = {1'b0, idle_idx};
                            ch_head_next = {1'b0, idle_idx};
                            av_nxt_next[idle_idx] = LNIL;
                            av_prv_next[idle_idx] = LNIL;
                            av_head_next = {1'b0, idle_idx};
                            cur_next   = idle_idx;
                            state_next = BK_POP;
                        end
                        else
                        begin
                            f_status  = STAT_NO_SPACE;
                            do_finish = 1'b1;
                        end
                    end
                endcase
            end
            BK_POP:
            begin
                if (head_reg[cur_reg] < fresh_reg[cur_reg])
                begin
                    // slot came back by a free: its link is in the RAM
                    mem_re     = 1'b1;
                    state_next = BK_WAIT;
                end
                else
                begin
                    nxt = (head_reg[cur_reg] + HW'(1) == n) ? SNIL : head_reg[cur_reg] + HW'(1);
                    fresh_next[cur_reg] = head_reg[cur_reg] + HW'(1);
                    do_pop = 1'b1;
                end
            end
            default: // BK_WAIT
            begin
                do_pop = 1'b1;
            end
        endcase

        if (do_pop)
        begin
            head_next[cur_reg]    = nxt;
            used_next[cur_reg][s] = 1'b1;
            cnt_next[cur_reg]     = cnt_reg[cur_reg] + HW'(1);
            total_next = total_reg + TW'(1);
            unlink_en  = nxt[SW];
            ub         = cur_reg;
            f_bank     = cur_reg;
            f_slot     = s;
            do_finish  = 1'b1;
        end

        if (unlink_en)
        begin
            lnx = av_nxt_next[ub];
            lpv = av_prv_next[ub];
            if (av_head_next == {1'b0, ub})
                av_head_next = lnx;
            else if (!lpv[IW])
                av_nxt_next[lpv[IW-1:0]] = lnx;
            if (!lnx[IW])
                av_prv_next[lnx[IW-1:0]] = lpv;
            av_nxt_next[ub] = LNIL;
            av_prv_next[ub] = LNIL;
        end

        if (push_en)
        begin
            old = av_head_next;
            av_head_next = {1'b0, ub};
            av_prv_next[ub] = LNIL;
            av_nxt_next[ub] = old;
            if (!old[IW])
                av_prv_next[old[IW-1:0]] = {1'b0, ub};
        end

        if (do_clear)
        begin
            for (int k = 0; k < NUM_BANKS; k++)
            begin
                if (active_reg[k])
                begin
                    used_next[k]   = '0;
                    cnt_next[k]    = '0;
                    head_next[k]   = '0;
                    fresh_next[k]  = '0;
                    av_prv_next[k] = ch_prv_reg[k];
                    av_nxt_next[k] = ch_nxt_reg[k];
                end
            end
            av_head_next = ch_head_reg;
            total_next   = '0;
        end

        if (do_finish)
        begin
            res_next.status         = f_status;
            res_next.granted_puddle = 3'(f_bank);
            res_next.granted_slot   = 6'(f_slot);
            res_next.is_allocated   = f_isal;
            res_next.total_used     = 10'(total_next);
            out_valid_next = 1'b1;
            state_next     = BK_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            spp_reg       <= 7'd64;
            nf_reg        <= 1'b0;
            active_reg    <= NUM_BANKS'(1);
            ch_head_reg   <= '0;
            av_head_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_BANKS; k++)
            begin
                used_reg[k]   <= '0;
                head_reg[k]   <= '0;
                fresh_reg[k]  <= '0;
                cnt_reg[k]    <= '0;
                av_nxt_reg[k] <= LNIL;
                av_prv_reg[k] <= LNIL;
                ch_nxt_reg[k] <= LNIL;
                ch_prv_reg[k] <= LNIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            spp_reg       <= spp_next;
            nf_reg        <= nf_next;
            active_reg    <= active_next;
            ch_head_reg   <= ch_head_next;
            av_head_reg   <= av_head_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            cnt_reg       <= cnt_next;
            av_nxt_reg    <= av_nxt_next;
            av_prv_reg    <= av_prv_next;
            ch_nxt_reg    <= ch_nxt_next;
            ch_prv_reg    <= ch_prv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

`ifndef SYNTHESIS
    a_wait_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WAIT) |-> ($past(state_reg) == BK_POP))
        else $error("RAM wait without a pop");
    a_one_bank_active: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg != '0)
        else $error("no active bank left");
    a_chain_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !ch_head_reg[IW] && active_reg[ch_head_reg[IW-1:0]])
        else $error("chain head not an active bank");
    a_avail_head_active: assert property (@(posedge clk) disable iff (!rst_n)
        !av_head_reg[IW] |-> active_reg[av_head_reg[IW-1:0]])
        else $error("available head is an idle bank");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("pending result overwritten");
`endif

endmodule

// ===== hw/rtl/slot_pool_allocator.sv =====
// Top level of the slot pool allocator: front queue, back engine, port packing.
//
// Usage:
//   s_axis carries commands: allocate, free, query, clear. m_axis returns one
//   result per command, in order. cfg writes the slot count (index 0, also
//   reinitializes every active bank like a clear) and the keep-banks flag
//   (index 1); write it only while no command is outstanding.
// Result path: free, query and clear finish in the execute state. Allocate goes on
//   to the pop state, also when it activates an idle bank, and on through a wait
//   state when the head slot's link comes from the free-list RAM; with no space
//   left it finishes in the execute state. The back engine runs one command at a
//   time; the RAM read of a recycled slot's link adds the wait state.
// The two-entry front queue takes items while a result waits, until full; a stalled
//   m_axis holds the result register and the engine waits before the next one.
// Reset: bank 0 active with all slots free, slot count 64, queue and result
//   register empty. No clearing pass: a bank's free list is built on demand.
module slot_pool_allocator
    import spa_pkg::*;
    #(
        parameter int NUM_BANKS = SPA_NUM_BANKS,
        parameter int SLOTS     = SPA_SLOTS
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        s_axis_tvalid,
        output logic        s_axis_tready,
        input  logic [15:0] s_axis_tdata,   // op[1:0], puddle_index[4:2], slot_index[10:5]
        output logic        m_axis_tvalid,
        input  logic        m_axis_tready,
        output logic [23:0] m_axis_tdata,   // status[1:0], granted_puddle[4:2],
                                            // granted_slot[10:5], is_allocated[11],
                                            // total_used[21:12]
        input  logic        cfg_valid,
        output logic        cfg_ready,
        input  logic [1:0]  cfg_index,
        input  logic [6:0]  cfg_data
    );

    spa_queue_out_t q_out;
    logic           q_ready;
    spa_result_t    res;

    spa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_out    (q_out),
        .q_ready  (q_ready)
    );

    spa_back #(.NUM_BANKS(NUM_BANKS), .SLOTS(SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_in      (q_out),
        .q_ready   (q_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    assign m_axis_tdata = {2'b00, res};

endmodule
